// File: rtl/ddo_pkg.sv
// Package for the differential drive odometry block.
// Holds opcodes, fixed-point constants and the CORDIC arctangent table.
// No dependencies.
`default_nettype none

package ddo_pkg;

  // Opcodes of the input beat
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // 2*pi in Q8.24
  localparam int unsigned TWO_PI_Q24      = 32'd105414357;
  // Inverse CORDIC gain in Q2.30
  localparam int unsigned CORDIC_GAIN_Q30 = 32'd652032874;

  // atan(2^-i) as a binary angle (2^32 = one turn)
  localparam logic [29:0] ATAN_TURNS [32] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
    30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
    30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
    30'd166886,    30'd83443,     30'd41722,     30'd20861,
    30'd10430,     30'd5215,      30'd2608,      30'd1304,
    30'd652,       30'd326,       30'd163,       30'd81,
    30'd41,        30'd20,        30'd10,        30'd5,
    30'd3,         30'd1,         30'd1,         30'd0
  };

endpackage

`default_nettype wire

// File: rtl/differential_drive_odometry.sv
// Differential drive wheel odometry, midpoint integration, bit-serial datapath.
// Depends on ddo_pkg (opcodes, constants, arctangent table).
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one beat per update: the
//   opcode and the absolute left and right encoder counts. Output channel
//   (out_valid_o/out_ready_i) returns one beat per input: the pose after it.
//   inv_track_width_we_i writes the 1/(2*dW) register (Q8.16);
//   write it only while the block is idle. Reset value is 1.0.
// Sequence:
//   An update runs from accept to result through a shift-add multiplier for
//   each of four products, a restoring divider for the travel and for the
//   heading change, one CORDIC iteration per cycle and the load of the
//   output register. The next beat can be taken in the same cycle as the
//   result shows. A clear skips the arithmetic and goes straight to the
//   output register. One item is in flight at a time; in_ready_o is high
//   when idle.
// Stall:
//   The result sits in an output register; when the receiver stalls, the
//   block holds it and finishes the next item only once that register frees.
// Reset:
//   Pose, previous counts and heading are zero, the register is 1.0.
`default_nettype none

module differential_drive_odometry
  import ddo_pkg::*;
#(
  parameter int COUNTS_PER_REV = 36000,
  parameter int CORDIC_STEPS   = 24
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        inv_track_width_we_i,
  input  wire logic [23:0] inv_track_width_i,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic        opcode_i,
  input  wire logic [31:0] left_count_i,
  input  wire logic [31:0] right_count_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic [31:0] pose_x_o,
  output      logic [31:0] pose_y_o,
  output      logic [31:0] pose_heading_o
);

  // Divisors of the two long divisions and their rounding thresholds
  localparam int DEN       = COUNTS_PER_REV * 512;
  localparam int DEN_HALF  = (DEN + 1) / 2;
  localparam int CPR_HALF  = (COUNTS_PER_REV + 1) / 2;
  localparam int MUL_LAST  = 32;  // 33 multiplier bits
  localparam int DIV1_LAST = 68;  // 69 product bits
  localparam int DIV2_HALF = 83;  // product bits plus 15 fraction bits
  localparam int DIV2_LAST = 84;  // product bits plus 16 fraction bits

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MUL1 = 4'd1;
  localparam logic [3:0] ST_DIV1 = 4'd2;
  localparam logic [3:0] ST_MUL2 = 4'd3;
  localparam logic [3:0] ST_DIV2 = 4'd4;
  localparam logic [3:0] ST_CORD = 4'd5;
  localparam logic [3:0] ST_MUL3 = 4'd6;
  localparam logic [3:0] ST_MUL4 = 4'd7;
  localparam logic [3:0] ST_OUT  = 4'd8;

  logic [3:0]  state_q;
  logic [6:0]  cnt_q;
  logic [23:0] itw_q;

  // Pose and previous counts
  logic [31:0] left_prev_q, right_prev_q, pos_x_q, pos_y_q, heading_q;

  // Per-item operands
  logic        sum_neg_q, diff_neg_q, d_neg_q;
  logic [32:0] diff_mag_q, d_mag_q;
  logic [31:0] half_q, full_q;

  // Shared product / numerator shift register, divider state
  logic [68:0] prod_q;
  logic [29:0] rem_q;
  logic [32:0] quo_q;
  logic        big_q;

  // CORDIC state and results
  logic signed [33:0] x_q, y_q, z_q;
  logic               flip_q;
  logic signed [34:0] c_q, s_q;

  logic        out_valid_q;
  logic [31:0] out_x_q, out_y_q, out_h_q;

  // ---------------- item decode on accept ----------------
  logic        accept;
  logic [31:0] dl, dr;
  logic [32:0] sum_v, diff_v, sum_mag, diff_mag;

  assign accept   = in_valid_i && in_ready_o;
  assign dl       = left_count_i - left_prev_q;
  assign dr       = right_count_i - right_prev_q;
  assign sum_v    = {dl[31], dl} + {dr[31], dr};
  assign diff_v   = {dr[31], dr} - {dl[31], dl};
  assign sum_mag  = sum_v[32] ? 33'(-sum_v) : sum_v;
  assign diff_mag = diff_v[32] ? 33'(-diff_v) : diff_v;

  // ---------------- serial multiplier step ----------------
  // Add the multiplicand into the high half when the low bit is set, then
  // shift the whole product right by one.
  logic [34:0] mul_a;
  logic [36:0] msum;
  logic [68:0] mul_prod;

  always_comb begin
    case (state_q)
      ST_MUL1: mul_a = 35'(TWO_PI_Q24);
      ST_MUL2: mul_a = {11'd0, itw_q};
      ST_MUL3: mul_a = c_q;
      ST_MUL4: mul_a = s_q;
      default: mul_a = '0;
    endcase
  end

  assign msum     = {prod_q[68], prod_q[68:33]}
                  + (prod_q[0] ? {{2{mul_a[34]}}, mul_a} : 37'd0);
  assign mul_prod = {msum, prod_q[32:1]};

  // Signed product of the travel with cos or sin, rounded to Q16.16
  logic [68:0] prod_sgn, prod_rnd;
  logic [38:0] inc;
  assign prod_sgn = d_neg_q ? 69'(-mul_prod) : mul_prod;
  assign prod_rnd = prod_sgn + 69'(1 << 29);
  assign inc      = prod_rnd[68:30];

  function automatic logic [31:0] sat_add(input logic [31:0] p, input logic [38:0] d);
    logic signed [39:0] v;
    v = signed'({{8{p[31]}}, p}) + signed'({d[38], d});
    if (v > 40'sd2147483647)       sat_add = 32'h7FFF_FFFF;
    else if (v < -40'sd2147483648) sat_add = 32'h8000_0000;
    else                           sat_add = v[31:0];
  endfunction

  // ---------------- restoring divider step ----------------
  logic [29:0] dvsr, rem_n;
  logic [30:0] dtry, dsub;
  logic        dge, big_n, up1, up2;
  logic [32:0] quo_n;
  logic [33:0] trav_r;
  logic [32:0] trav_mag;
  logic [31:0] turn_r, turn_s;

  assign dvsr  = (state_q == ST_DIV1) ? 30'(DEN) : 30'(COUNTS_PER_REV);
  assign dtry  = {rem_q, prod_q[68]};
  assign dsub  = dtry - {1'b0, dvsr};
  assign dge   = dtry >= {1'b0, dvsr};
  assign rem_n = dge ? dsub[29:0] : dtry[29:0];
  assign quo_n = {quo_q[31:0], dge};
  assign big_n = big_q | quo_q[32];
  assign up1   = rem_n >= 30'(DEN_HALF);
  assign up2   = rem_n >= 30'(CPR_HALF);

  // Travel magnitude, saturated to one 2^32 in Q16.16
  assign trav_r   = {1'b0, quo_n} + 34'(up1);
  assign trav_mag = (big_n || trav_r > 34'h1_0000_0000) ? 33'h1_0000_0000
                                                        : trav_r[32:0];
  // Heading change, rounded and signed
  assign turn_r = quo_n[31:0] + 32'(up2);
  assign turn_s = diff_neg_q ? 32'(-turn_r) : turn_r;

  // ---------------- CORDIC iteration ----------------
  logic [31:0]        ang, ang_off, ang_fold;
  logic               flip_n;
  logic [4:0]         idx;
  logic signed [33:0] xs, ys, at, x_n, y_n, z_n;

  assign ang      = heading_q + half_q;
  assign ang_off  = ang + 32'h4000_0000;
  assign flip_n   = ang_off[31];
  assign ang_fold = flip_n ? ang + 32'h8000_0000 : ang;

  assign idx = cnt_q[4:0];
  assign xs  = x_q >>> idx;
  assign ys  = y_q >>> idx;
  assign at  = signed'({4'd0, ATAN_TURNS[idx]});
  assign x_n = z_q[33] ? x_q + ys : x_q - ys;
  assign y_n = z_q[33] ? y_q - xs : y_q + xs;
  assign z_n = z_q[33] ? z_q + at : z_q - at;

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      itw_q        <= 24'd65536;
      left_prev_q  <= '0;
      right_prev_q <= '0;
      pos_x_q      <= '0;
      pos_y_q      <= '0;
      heading_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (inv_track_width_we_i) itw_q <= inv_track_width_i;
      if (out_valid_q && out_ready_i && state_q != ST_OUT) out_valid_q <= 1'b0;

      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            cnt_q <= '0;
            if (opcode_i == OP_CLEAR) begin
              left_prev_q  <= '0;
              right_prev_q <= '0;
              pos_x_q      <= '0;
              pos_y_q      <= '0;
              heading_q    <= '0;
              state_q      <= ST_OUT;
            end else begin
              left_prev_q  <= left_count_i;
              right_prev_q <= right_count_i;
              state_q      <= ST_MUL1;
            end
          end
        end
        ST_MUL1, ST_MUL2: begin
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == 7'(MUL_LAST)) begin
            cnt_q   <= '0;
            state_q <= (state_q == ST_MUL1) ? ST_DIV1 : ST_DIV2;
          end
        end
        ST_DIV1: begin
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == 7'(DIV1_LAST)) begin
            cnt_q   <= '0;
            state_q <= ST_MUL2;
          end
        end
        ST_DIV2: begin
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == 7'(DIV2_LAST)) begin
            cnt_q   <= '0;
            state_q <= ST_CORD;
          end
        end
        ST_CORD: begin
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == 7'(CORDIC_STEPS - 1)) begin
            cnt_q   <= '0;
            state_q <= ST_MUL3;
          end
        end
        ST_MUL3: begin
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == 7'(MUL_LAST)) begin
            cnt_q   <= '0;
            pos_x_q <= sat_add(pos_x_q, inc);
            state_q <= ST_MUL4;
          end
        end
        ST_MUL4: begin
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == 7'(MUL_LAST)) begin
            cnt_q     <= '0;
            pos_y_q   <= sat_add(pos_y_q, inc);
            heading_q <= heading_q + full_q;
            state_q   <= ST_OUT;
          end
        end
        ST_OUT: begin
          // Hold the result until the output register is free
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers, no reset
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        sum_neg_q  <= sum_v[32];
        diff_neg_q <= diff_v[32];
        diff_mag_q <= diff_mag;
        prod_q     <= {36'd0, sum_mag};
      end
      ST_MUL1, ST_MUL2, ST_MUL3, ST_MUL4: begin
        rem_q  <= '0;
        quo_q  <= '0;
        big_q  <= 1'b0;
        if (cnt_q == 7'(MUL_LAST) && state_q == ST_MUL3) prod_q <= {36'd0, d_mag_q};
        else prod_q <= mul_prod;
      end
      ST_DIV1, ST_DIV2: begin
        rem_q  <= rem_n;
        quo_q  <= quo_n;
        big_q  <= big_n;
        if (state_q == ST_DIV1 && cnt_q == 7'(DIV1_LAST)) begin
          d_mag_q <= trav_mag;
          d_neg_q <= sum_neg_q;
          prod_q  <= {36'd0, diff_mag_q};
        end else begin
          prod_q <= {prod_q[67:0], 1'b0};
        end
        if (state_q == ST_DIV2 && cnt_q == 7'(DIV2_HALF)) half_q <= turn_s;
        if (state_q == ST_DIV2 && cnt_q == 7'(DIV2_LAST)) begin
          full_q <= turn_s;
        end
      end
      ST_CORD: begin
        x_q <= x_n;
        y_q <= y_n;
        z_q <= z_n;
        if (cnt_q == 7'(CORDIC_STEPS - 1)) begin
          c_q    <= flip_q ? 35'(-{x_n[33], x_n}) : {x_n[33], x_n};
          s_q    <= flip_q ? 35'(-{y_n[33], y_n}) : {y_n[33], y_n};
          prod_q <= {36'd0, d_mag_q};
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_x_q <= pos_x_q;
          out_y_q <= pos_y_q;
          out_h_q <= heading_q;
        end
      end
      default: begin
      end
    endcase
    // Load the CORDIC at the end of the heading division, once half is known;
    // start from the midpoint heading folded into [-1/4, 1/4) of a turn
    if (state_q == ST_DIV2 && cnt_q == 7'(DIV2_LAST)) begin
      x_q <= 34'(CORDIC_GAIN_Q30);
      y_q <= '0;
      z_q <= {{2{ang_fold[31]}}, ang_fold};
    end
  end

  // Note the half-turn fold; it negates cos and sin at the end
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DIV2 && cnt_q == 7'(DIV2_LAST)) flip_q <= flip_n;
  end

  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign pose_x_o       = out_x_q;
  assign pose_y_o       = out_y_q;
  assign pose_heading_o = out_h_q;

endmodule

`default_nettype wire
